@@ hw/rtl/spfp_pkg.sv @@
`timescale 1ns / 1ps

package spfp_pkg;

	localparam int AXIS_COUNT_DEF = 4;

	localparam logic [7:0] TRAILER_BYTE  = 8'h6B;
	localparam logic [7:0] CODE_POSITION = 8'h36;
	localparam logic [7:0] CODE_SPEED    = 8'h35;
	localparam logic [7:0] CODE_FLAGS    = 8'h3A;
	localparam logic [7:0] CODE_ZERO     = 8'h0A;
	localparam logic [7:0] CODE_ENABLE   = 8'hF3;
	localparam logic [7:0] CODE_STOP     = 8'hFE;
	localparam logic [7:0] CODE_MISC     = 8'hFD;
	localparam logic [7:0] STATUS_OK     = 8'h02;

	localparam logic [11:0] TENTHS_PER_TURN = 12'd3600;
	localparam logic [27:0] ROUND_HALF      = 28'd32768;

	localparam logic [11:0] MAX_ANGLE_RST = 12'd1800;
	localparam logic signed [12:0] MIN_ANGLE_RST = -13'sd1800;

	typedef enum logic {
		CFG_MAX_ANGLE = 1'b0,
		CFG_MIN_ANGLE = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		KIND_POSITION = 3'd0,
		KIND_SPEED    = 3'd1,
		KIND_FLAGS    = 3'd2,
		KIND_ZERO     = 3'd3,
		KIND_ENABLE   = 3'd4,
		KIND_STOP     = 3'd5,
		KIND_OTHER    = 3'd6
	} reply_kind_t;

	// bytes of the frame in flight that the decoder looks at
	typedef struct packed {
		logic [7:0]  addr;
		logic [7:0]  code;
		logic [7:0]  status;
		logic [7:0]  data3;
		logic [7:0]  data4;
		logic [11:0] mag_tenths;
		logic [7:0]  trailer;
	} frame_t;

	typedef struct packed {
		logic [1:0]         axis;
		reply_kind_t        kind;
		logic signed [11:0] pos_tenths;
		logic signed [15:0] rpm;
		logic [7:0]         status_flags;
		logic               enabled;
		logic               stall_res;
	} result_t;

	function automatic logic [3:0] code_length(input logic [7:0] code);
		logic [3:0] len;
		unique case (code)
			CODE_POSITION: len = 4'd8;
			CODE_SPEED:    len = 4'd6;
			CODE_FLAGS,
			CODE_ZERO,
			CODE_ENABLE,
			CODE_MISC,
			CODE_STOP:     len = 4'd4;
			default:       len = 4'd0;
		endcase
		return len;
	endfunction

endpackage

@@ hw/rtl/spfp_decode.sv @@
`timescale 1ns / 1ps

module spfp_decode (
	input  spfp_pkg::frame_t           frame,
	input  logic [11:0]                max_angle,
	input  logic signed [12:0]         min_angle,
	output logic                       ok,
	output spfp_pkg::result_t          res
);

	logic signed [13:0] ang_signed;
	logic signed [13:0] ang_wrapped;
	logic signed [11:0] ang_sat;
	logic [15:0]        spd_raw;

	always_comb begin
		ang_signed = (frame.status != 8'd0) ? -$signed({2'b00, frame.mag_tenths})
		                                    :  $signed({2'b00, frame.mag_tenths});
		if (ang_signed > $signed({2'b00, max_angle})) begin
			ang_wrapped = ang_signed - $signed({2'b00, spfp_pkg::TENTHS_PER_TURN});
		end else if (ang_signed < 14'(min_angle)) begin
			ang_wrapped = ang_signed + $signed({2'b00, spfp_pkg::TENTHS_PER_TURN});
		end else begin
			ang_wrapped = ang_signed;
		end
		if (ang_wrapped > 14'sd2047) begin
			ang_sat = 12'sd2047;
		end else if (ang_wrapped < -14'sd2048) begin
			ang_sat = -12'sd2048;
		end else begin
			ang_sat = ang_wrapped[11:0];
		end
	end

	assign spd_raw = {frame.data3, frame.data4};
	assign ok      = (frame.trailer == spfp_pkg::TRAILER_BYTE);

	always_comb begin
		res      = '0;
		res.axis = 2'(frame.addr - 8'd1);
		priority if (frame.code == spfp_pkg::CODE_POSITION) begin
			res.kind       = spfp_pkg::KIND_POSITION;
			res.pos_tenths = ang_sat;
		end else if (frame.code == spfp_pkg::CODE_SPEED) begin
			res.kind = spfp_pkg::KIND_SPEED;
			res.rpm  = (frame.status != 8'd0) ? $signed(16'd0 - spd_raw) : $signed(spd_raw);
		end else if (frame.code == spfp_pkg::CODE_FLAGS) begin
			res.kind         = spfp_pkg::KIND_FLAGS;
			res.status_flags = frame.status;
			res.enabled      = frame.status[0];
			res.stall_res    = |frame.status[3:2];
		end else if (frame.code == spfp_pkg::CODE_ZERO && frame.status == spfp_pkg::STATUS_OK) begin
			res.kind = spfp_pkg::KIND_ZERO;
		end else if (frame.code == spfp_pkg::CODE_ENABLE
		             && frame.status == spfp_pkg::STATUS_OK) begin
			res.kind = spfp_pkg::KIND_ENABLE;
		end else if (frame.code == spfp_pkg::CODE_STOP && frame.status == spfp_pkg::STATUS_OK) begin
			res.kind = spfp_pkg::KIND_STOP;
		end else begin
			res.kind = spfp_pkg::KIND_OTHER;
		end
	end

endmodule

@@ hw/rtl/stepper_reply_frame_parser_unit.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                   Direction  Transaction
// -------   ---------------------------------------   ---------  -------------------------
// in        in_valid/in_ready, rx_byte                sink       one received bus byte
// out       out_valid/out_ready, axis, reply_kind,    source     one decoded reply
//           pos_tenths, rpm, status_flags,
//           enabled, stall_res
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  sink       one angle limit write
//
// One byte per cycle while in_ready is high. The frame state updates in the cycle a byte is taken; the
// reply for a frame is registered on the trailer byte and shows on out in the cycle after.
// Reset clears the hunt state and the output valid, and sets the limits to 1800 / -1800.
// A held result only blocks input while out_ready is low; draining it frees in the same cycle.
// cfg_ready is always high; limits should only change while no frame is in flight.

module stepper_reply_frame_parser_unit #(
	parameter int AXIS_COUNT = spfp_pkg::AXIS_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         axis,
	output logic [2:0]         reply_kind,
	output logic signed [11:0] pos_tenths,
	output logic signed [15:0] rpm,
	output logic [7:0]         status_flags,
	output logic               enabled,
	output logic               stall_res,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [12:0]        cfg_data
);

	// hunt / collect state: count of bytes taken in the current frame
	logic [2:0]  cnt_q, cnt_d;
	logic [3:0]  len_q, len_d;

	// captured frame bytes (fixed slots, no reset needed)
	logic [7:0]  addr_q, code_q, status_q, data3_q, data4_q, data5_q;
	logic [11:0] mag_q;

	logic [11:0]        max_angle_q;
	logic signed [12:0] min_angle_q;

	logic               out_valid_q;
	spfp_pkg::result_t  res_q;

	logic               in_fire;
	logic               is_addr;
	logic [3:0]         byte_len;
	logic               frame_done;
	logic [27:0]        turn_prod;
	spfp_pkg::frame_t   frame;
	logic               dec_ok;
	spfp_pkg::result_t  dec_res;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign is_addr  = (rx_byte >= 8'd1) && (rx_byte <= 8'(AXIS_COUNT));
	assign byte_len = spfp_pkg::code_length(rx_byte);

	// frame is complete when this byte brings the count up to the expected length
	assign frame_done = (cnt_q >= 3'd2) && ({1'b0, cnt_q} + 4'd1 == len_q);

	// position rounding: (raw * 3600 + 32768) >> 16, done as byte six lands
	assign turn_prod = 28'({data5_q, rx_byte}) * 28'(spfp_pkg::TENTHS_PER_TURN)
	                 + spfp_pkg::ROUND_HALF;

	always_comb begin
		frame.addr       = addr_q;
		frame.code       = code_q;
		frame.status     = status_q;
		frame.data3      = data3_q;
		frame.data4      = data4_q;
		frame.mag_tenths = mag_q;
		frame.trailer    = rx_byte;
	end

	spfp_decode u_decode (
		.frame     (frame),
		.max_angle (max_angle_q),
		.min_angle (min_angle_q),
		.ok        (dec_ok),
		.res       (dec_res)
	);

	always_comb begin
		cnt_d = cnt_q;
		len_d = len_q;
		if (in_fire) begin
			priority if (cnt_q == 3'd1 && byte_len != 4'd0) begin
				cnt_d = 3'd2;
				len_d = byte_len;
			end else if (cnt_q <= 3'd1) begin
				// hunting, or an unknown code retried as an address
				cnt_d = is_addr ? 3'd1 : 3'd0;
				len_d = 4'd0;
			end else if (frame_done) begin
				cnt_d = 3'd0;
				len_d = 4'd0;
			end else begin
				cnt_d = cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			len_q <= 4'd0;
		end else begin
			cnt_q <= cnt_d;
			len_q <= len_d;
		end
	end

	// byte slots
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (cnt_q == 3'd1 && byte_len != 4'd0) begin
				code_q <= rx_byte;
			end else if (cnt_q <= 3'd1) begin
				if (is_addr) begin
					addr_q <= rx_byte;
				end
			end else begin
				unique case (cnt_q)
					3'd2:    status_q <= rx_byte;
					3'd3:    data3_q  <= rx_byte;
					3'd4:    data4_q  <= rx_byte;
					3'd5:    data5_q  <= rx_byte;
					3'd6:    mag_q    <= turn_prod[27:16];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_angle_q <= spfp_pkg::MAX_ANGLE_RST;
			min_angle_q <= spfp_pkg::MIN_ANGLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (spfp_pkg::cfg_index_t'(cfg_index))
				spfp_pkg::CFG_MAX_ANGLE: max_angle_q <= cfg_data[11:0];
				spfp_pkg::CFG_MIN_ANGLE: min_angle_q <= $signed(cfg_data);
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && frame_done && dec_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && frame_done && dec_ok) begin
			res_q <= dec_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign axis         = res_q.axis;
	assign reply_kind   = res_q.kind;
	assign pos_tenths   = res_q.pos_tenths;
	assign rpm          = res_q.rpm;
	assign status_flags = res_q.status_flags;
	assign enabled      = res_q.enabled;
	assign stall_res    = res_q.stall_res;

	// collecting past the code byte always has a known length
	a_len_known: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= 3'd2 |-> (len_q == 4'd4 || len_q == 4'd6 || len_q == 4'd8))
		else $error("frame length lost while collecting");

	// a non-address byte while hunting leaves the parser hunting
	a_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cnt_q == 3'd0 && !is_addr |=> cnt_q == 3'd0)
		else $error("non-address byte opened a frame");

	// a new reply only follows a completed frame
	a_reply_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_fire && frame_done))
		else $error("reply without a completed frame");

	// input stalls only behind a held reply
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready)
		else $error("input stalled without a pending reply");

endmodule

@@ verif/stepper_reply_frame_parser_unit_tb.sv @@
`timescale 1ns / 1ps

// Byte-level testbench for the stepper reply frame parser.
// A table of directed bus bytes runs first, then random frames under a series
// of angle limit settings. Every reply transaction is checked against a local
// frame decoder that tracks the parser state byte by byte, or a hand-typed reply.

module stepper_reply_frame_parser_unit_tb;

	import spfp_pkg::*;

	localparam int AXIS_COUNT  = AXIS_COUNT_DEF;
	localparam int FRAME_BYTES = 16;
	localparam int SETTLE      = 4;       // reply shows in the cycle after the trailer
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 165;     // counted bytes per limit setting
	localparam int N_SETTINGS  = 7;

	// directed stimulus row: one bus byte, optionally with a hand-typed reply
	typedef struct {
		logic [7:0] rx;
		bit         has_want;
		result_t    want;
	} frame_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         axis;
	logic [2:0]         reply_kind;
	logic signed [11:0] pos_tenths;
	logic signed [15:0] rpm;
	logic [7:0]         status_flags;
	logic               enabled;
	logic               stall_res;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [12:0]        cfg_data;

	// decoder copy of the parser state and the angle limits
	logic [7:0] frm_buf [FRAME_BYTES];
	int         frm_fill;
	int         frm_len;
	int         lim_max;
	int         lim_min;

	result_t    pending_replies[$];
	frame_row_t dir_rows[$];

	bit idle_on;
	int errors     = 0;
	int cycle_cnt  = 0;
	int bytes_sent = 0;
	int bytes_used = 0;
	int cfg_writes = 0;
	int kind_seen [7];

	stepper_reply_frame_parser_unit #(
		.AXIS_COUNT(AXIS_COUNT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.axis         (axis),
		.reply_kind   (reply_kind),
		.pos_tenths   (pos_tenths),
		.rpm          (rpm),
		.status_flags (status_flags),
		.enabled      (enabled),
		.stall_res    (stall_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Advance the frame decoder by one accepted byte; got is set when the byte
	// closes a frame with a good trailer.
	task automatic parse_rx_byte(input logic [7:0] b, output bit got, output result_t rep);
		int          len;
		int          raw;
		int          ang;
		logic [7:0]  st;
		logic [16:0] spd;
		got = 1'b0;
		rep = '0;
		// function code: fixes the length, or drops the frame and the byte
		// gets another look as an address
		if (frm_fill == 1) begin
			case (b)
				CODE_POSITION: len = 8;
				CODE_SPEED:    len = 6;
				CODE_FLAGS, CODE_ZERO, CODE_ENABLE, CODE_STOP, CODE_MISC: len = 4;
				default:       len = 0;
			endcase
			if (len == 0) begin
				frm_fill = 0;
				frm_len  = 0;
			end else begin
				frm_buf[1] = b;
				frm_len    = len;
				frm_fill   = 2;
			end
		end else if (frm_fill >= FRAME_BYTES) begin
			// overflow drops the frame and the byte with it
			frm_fill = 0;
			frm_len  = 0;
			return;
		end else if (frm_fill > 1) begin
			frm_buf[frm_fill] = b;
			frm_fill++;
		end
		if (frm_fill == 0) begin
			// hunting: only 1..AXIS_COUNT opens a frame
			if (b >= 1 && b <= AXIS_COUNT) begin
				frm_buf[0] = b;
				frm_fill   = 1;
			end
		end else if (frm_len != 0 && frm_fill >= frm_len) begin
			if (frm_buf[frm_len - 1] == TRAILER_BYTE) begin
				got      = 1'b1;
				st       = frm_buf[2];
				rep.axis = 2'(frm_buf[0] - 8'd1);
				case (frm_buf[1])
					CODE_POSITION: begin
						// round to tenths, sign, wrap into the limits, clamp to 12 bits
						raw = {frm_buf[5], frm_buf[6]};
						ang = (raw * 3600 + 32768) / 65536;
						if (st != 8'h00) ang = -ang;
						if (ang > lim_max) ang -= 3600;
						else if (ang < lim_min) ang += 3600;
						if (ang > 2047) ang = 2047;
						if (ang < -2048) ang = -2048;
						rep.kind       = KIND_POSITION;
						rep.pos_tenths = ang[11:0];
					end
					CODE_SPEED: begin
						spd = {1'b0, frm_buf[3], frm_buf[4]};
						if (st != 8'h00) spd = 17'h10000 - spd;
						rep.kind = KIND_SPEED;
						rep.rpm  = spd[15:0];
					end
					CODE_FLAGS: begin
						rep.kind         = KIND_FLAGS;
						rep.status_flags = st;
						rep.enabled      = st[0];
						rep.stall_res    = |st[3:2];
					end
					CODE_ZERO: begin
						if (st == STATUS_OK) rep.kind = KIND_ZERO;
						else rep.kind = KIND_OTHER;
					end
					CODE_ENABLE: begin
						if (st == STATUS_OK) rep.kind = KIND_ENABLE;
						else rep.kind = KIND_OTHER;
					end
					CODE_STOP: begin
						if (st == STATUS_OK) rep.kind = KIND_STOP;
						else rep.kind = KIND_OTHER;
					end
					default: rep.kind = KIND_OTHER;
				endcase
			end
			frm_fill = 0;
			frm_len  = 0;
		end
	endtask

	// One input transaction, with an optional idle burst ahead of it.
	task automatic send_byte(input logic [7:0] b, input bit has_want, input result_t want);
		int      gap;
		bit      got;
		result_t rep;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// bytes dropped while hunting don't count toward the stimulus budget
		if (frm_fill != 0 || (b >= 1 && b <= AXIS_COUNT)) bytes_used++;
		bytes_sent++;
		parse_rx_byte(b, got, rep);
		if (got) begin
			if (has_want) pending_replies.push_back(want);
			else pending_replies.push_back(rep);
		end
	endtask

	// Mostly well-formed frames with random content; the rest is line noise,
	// unknown codes, bad trailers and frames cut short.
	task automatic run_random(input int n_items);
		logic [7:0]  fr[$];
		logic [7:0]  ad;
		logic [7:0]  st;
		logic [7:0]  tr;
		logic [15:0] val;
		int          pick;
		int          stop_at;
		stop_at = bytes_used + n_items;
		while (bytes_used < stop_at) begin
			fr.delete();
			pick = $urandom_range(0, 99);
			ad   = 8'($urandom_range(1, AXIS_COUNT));
			tr   = TRAILER_BYTE;
			if ($urandom_range(0, 9) == 0) tr = 8'($urandom);
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 3))
					0:       val = 16'h0000;
					1:       val = 16'hFFFF;
					2:       val = 16'h8000;
					default: val = 16'h0001;
				endcase
			end else begin
				val = 16'($urandom);
			end
			st = 8'($urandom);
			// sign byte: positive half the time for position and speed
			if (pick < 34 && $urandom_range(0, 1) == 1) st = 8'h00;
			// acknowledgements mostly carry the OK status
			if (pick >= 48 && pick < 80 && $urandom_range(0, 3) != 0) st = STATUS_OK;
			if (pick < 18) begin
				fr.push_back(ad);
				fr.push_back(CODE_POSITION);
				fr.push_back(st);
				fr.push_back(8'($urandom));
				fr.push_back(8'($urandom));
				fr.push_back(val[15:8]);
				fr.push_back(val[7:0]);
				fr.push_back(tr);
			end else if (pick < 34) begin
				fr.push_back(ad);
				fr.push_back(CODE_SPEED);
				fr.push_back(st);
				fr.push_back(val[15:8]);
				fr.push_back(val[7:0]);
				fr.push_back(tr);
			end else if (pick < 80) begin
				fr.push_back(ad);
				if (pick < 48) fr.push_back(CODE_FLAGS);
				else if (pick < 58) fr.push_back(CODE_ZERO);
				else if (pick < 66) fr.push_back(CODE_ENABLE);
				else if (pick < 74) fr.push_back(CODE_STOP);
				else fr.push_back(CODE_MISC);
				fr.push_back(st);
				fr.push_back(tr);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom));
			end else if (pick < 94) begin
				// address then any code byte, usually unknown
				fr.push_back(ad);
				fr.push_back(8'($urandom));
			end else begin
				// frame cut short: the next frame's bytes land inside it
				fr.push_back(ad);
				fr.push_back(CODE_POSITION);
				repeat ($urandom_range(0, 3)) fr.push_back(8'($urandom));
			end
			foreach (fr[i]) send_byte(fr[i], 1'b0, '0);
		end
	endtask

	// Both limit registers, back to back on the config channel.
	task automatic write_limits(input int hi, input int lo);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAX_ANGLE;
		cfg_data  <= hi[12:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		lim_max   = hi;
		cfg_index <= CFG_MIN_ANGLE;
		cfg_data  <= lo[12:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		lim_min   = lo;
		cfg_valid <= 1'b0;
		cfg_writes += 2;
	endtask

	function automatic result_t mk_reply(input logic [1:0] ax, input reply_kind_t k,
			input logic [15:0] sp, input logic [7:0] fl, input logic en, input logic stl);
		result_t r;
		r              = '0;
		r.axis         = ax;
		r.kind         = k;
		r.rpm          = sp;
		r.status_flags = fl;
		r.enabled      = en;
		r.stall_res    = stl;
		return r;
	endfunction

	function automatic frame_row_t row_plain(input logic [7:0] b);
		frame_row_t r;
		r.rx       = b;
		r.has_want = 1'b0;
		r.want     = '0;
		return r;
	endfunction

	function automatic frame_row_t row_typed(input logic [7:0] b, input result_t want);
		frame_row_t r;
		r.rx       = b;
		r.has_want = 1'b1;
		r.want     = want;
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	// Reply side: random backpressure bursts, and a field-by-field check of
	// every output transaction against the oldest pending reply.
	initial begin
		int      stall_left;
		result_t want;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected reply: axis %0d kind %0d", $time, axis, reply_kind);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					check_field("axis", want.axis, axis);
					check_field("reply_kind", want.kind, reply_kind);
					check_field("pos_tenths", want.pos_tenths, pos_tenths);
					check_field("rpm", want.rpm, rpm);
					check_field("status_flags", want.status_flags, status_flags);
					check_field("enabled", want.enabled, enabled);
					check_field("stall_res", want.stall_res, stall_res);
					kind_seen[want.kind]++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt,
			pending_replies.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int hi;
		int lo;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAX_ANGLE;
		cfg_data  = '0;
		idle_on   = 1'b1;
		frm_fill  = 0;
		frm_len   = 0;
		lim_max   = MAX_ANGLE_RST;
		lim_min   = MIN_ANGLE_RST;
		foreach (kind_seen[k]) kind_seen[k] = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset limits in force
		dir_rows.push_back(row_plain(8'h00));            // not an address: dropped
		dir_rows.push_back(row_plain(8'h01));
		dir_rows.push_back(row_plain(8'h04));            // unknown code, reopens as axis 3
		dir_rows.push_back(row_plain(CODE_FLAGS));
		dir_rows.push_back(row_plain(8'h0D));            // enable + stall-protect bits
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd3, KIND_FLAGS, 16'h0000, 8'h0D, 1'b1, 1'b1)));
		dir_rows.push_back(row_plain(8'h01));            // full-turn negative position
		dir_rows.push_back(row_plain(CODE_POSITION));
		dir_rows.push_back(row_plain(8'h01));
		dir_rows.push_back(row_plain(8'h00));
		dir_rows.push_back(row_plain(8'h00));
		dir_rows.push_back(row_plain(8'hFF));
		dir_rows.push_back(row_plain(8'hFF));
		dir_rows.push_back(row_plain(TRAILER_BYTE));
		dir_rows.push_back(row_plain(8'h04));            // top speed, positive
		dir_rows.push_back(row_plain(CODE_SPEED));
		dir_rows.push_back(row_plain(8'h00));
		dir_rows.push_back(row_plain(8'hFF));
		dir_rows.push_back(row_plain(8'hFF));
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd3, KIND_SPEED, 16'hFFFF, 8'h00, 1'b0, 1'b0)));
		dir_rows.push_back(row_plain(8'h03));
		dir_rows.push_back(row_plain(CODE_ZERO));
		dir_rows.push_back(row_plain(STATUS_OK));
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd2, KIND_ZERO, 16'h0000, 8'h00, 1'b0, 1'b0)));
		dir_rows.push_back(row_plain(8'h02));
		dir_rows.push_back(row_plain(CODE_ENABLE));
		dir_rows.push_back(row_plain(STATUS_OK));
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd1, KIND_ENABLE, 16'h0000, 8'h00, 1'b0, 1'b0)));
		dir_rows.push_back(row_plain(8'h01));
		dir_rows.push_back(row_plain(CODE_STOP));
		dir_rows.push_back(row_plain(STATUS_OK));
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd0, KIND_STOP, 16'h0000, 8'h00, 1'b0, 1'b0)));
		dir_rows.push_back(row_plain(8'h01));            // stop ack, status not OK
		dir_rows.push_back(row_plain(CODE_STOP));
		dir_rows.push_back(row_plain(8'h03));
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd0, KIND_OTHER, 16'h0000, 8'h00, 1'b0, 1'b0)));
		dir_rows.push_back(row_plain(8'h04));            // misc code: always other
		dir_rows.push_back(row_plain(CODE_MISC));
		dir_rows.push_back(row_plain(STATUS_OK));
		dir_rows.push_back(row_typed(TRAILER_BYTE,
			mk_reply(2'd3, KIND_OTHER, 16'h0000, 8'h00, 1'b0, 1'b0)));
		dir_rows.push_back(row_plain(8'h01));            // bad trailer: no reply
		dir_rows.push_back(row_plain(CODE_ZERO));
		dir_rows.push_back(row_plain(STATUS_OK));
		dir_rows.push_back(row_plain(8'h00));
		foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].has_want, dir_rows[i].want);

		run_random(PHASE_BYTES);

		for (int p = 0; p < N_SETTINGS; p++) begin
			// limits only change with the parser hunting and the reply path empty
			while (frm_fill != 0) send_byte(8'h00, 1'b0, '0);
			in_valid <= 1'b0;
			while (pending_replies.size() != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
			case (p)
				0: begin hi = 3600; lo = -3600; end
				1: begin hi = 0;    lo = 0;     end
				2: begin hi = 0;    lo = -3600; end
				3: begin hi = 3600; lo = 0;     end
				4, 5: begin
					hi = $urandom_range(0, 3600);
					lo = $urandom_range(0, 3600);
					lo = -lo;
				end
				default: begin hi = MAX_ANGLE_RST; lo = MIN_ANGLE_RST; end
			endcase
			write_limits(hi, lo);
			// last stretch runs at full rate on both sides
			idle_on = (p != N_SETTINGS - 1);
			run_random(PHASE_BYTES);
		end

		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d bus bytes (%0d in frames), %0d limit writes over %0d settings",
			bytes_sent, bytes_used, cfg_writes, N_SETTINGS + 1);
		$display("replies: position %0d speed %0d flags %0d zero %0d enable %0d stop %0d other %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5], kind_seen[6]);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
